// ----- src/fax_g3_1d_run_length_encoder_assert.svh -----
// Assertion macros shared by the encoder modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef FAX_G3_1D_RUN_LENGTH_ENCODER_ASSERT_SVH
`define FAX_G3_1D_RUN_LENGTH_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every clock edge outside reset
`define FAX_G3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fax_g3 check failed");

// consequent checked in the cycle after the antecedent
`define FAX_G3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fax_g3 next-cycle check failed");

`else

`define FAX_G3_ASSERT(lbl, prop)
`define FAX_G3_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/fax_g3_pkg.sv -----
`default_nettype none

package fax_g3_pkg;

  // code word and its bit count
  typedef struct packed {
    logic [12:0] bits;
    logic [3:0]  len;
  } code_t;

  // runs that end on one pixel: A ends at a colour change or line start,
  // B ends at the end of the line
  typedef struct packed {
    logic [3:0]  mask;
    logic        a_colour;
    logic [11:0] a_len;
    logic        b_colour;
    logic [11:0] b_len;
  } evt_t;

  // code slots inside an event, sent in this order
  localparam int SLOT_A_MK = 0;
  localparam int SLOT_A_TM = 1;
  localparam int SLOT_B_MK = 2;
  localparam int SLOT_B_TM = 3;

  localparam logic COLOUR_WHITE = 1'b0;
  localparam logic COLOUR_BLACK = 1'b1;

  localparam logic [11:0] LINE_WIDTH_RESET = 12'd1728;
  localparam logic [5:0]  MAKEUP_LAST      = 6'd40;
  localparam logic [5:0]  MAKEUP_STD_LAST  = 6'd27;
  localparam logic [5:0]  MAKEUP_EXT_FIRST = 6'd28;

  // entries are {code, len}: code in the upper 13 bits, len in the low 4
  localparam logic [16:0] WHITE_TERM [64] = '{
    17'h358, 17'h076, 17'h074, 17'h084, 17'h0b4, 17'h0c4, 17'h0e4, 17'h0f4,
    17'h135, 17'h145, 17'h075, 17'h085, 17'h086, 17'h036, 17'h346, 17'h356,
    17'h2a6, 17'h2b6, 17'h277, 17'h0c7, 17'h087, 17'h177, 17'h037, 17'h047,
    17'h287, 17'h2b7, 17'h137, 17'h247, 17'h187, 17'h028, 17'h038, 17'h1a8,
    17'h1b8, 17'h128, 17'h138, 17'h148, 17'h158, 17'h168, 17'h178, 17'h288,
    17'h298, 17'h2a8, 17'h2b8, 17'h2c8, 17'h2d8, 17'h048, 17'h058, 17'h0a8,
    17'h0b8, 17'h528, 17'h538, 17'h548, 17'h558, 17'h248, 17'h258, 17'h588,
    17'h598, 17'h5a8, 17'h5b8, 17'h4a8, 17'h4b8, 17'h328, 17'h338, 17'h348
  };

  localparam logic [16:0] BLACK_TERM [64] = '{
    17'h37a, 17'h023, 17'h032, 17'h022, 17'h033, 17'h034, 17'h024, 17'h035,
    17'h056, 17'h046, 17'h047, 17'h057, 17'h077, 17'h048, 17'h078, 17'h189,
    17'h17a, 17'h18a, 17'h08a, 17'h67b, 17'h68b, 17'h6cb, 17'h37b, 17'h28b,
    17'h17b, 17'h18b, 17'hcac, 17'hcbc, 17'hccc, 17'hcdc, 17'h68c, 17'h69c,
    17'h6ac, 17'h6bc, 17'hd2c, 17'hd3c, 17'hd4c, 17'hd5c, 17'hd6c, 17'hd7c,
    17'h6cc, 17'h6dc, 17'hdac, 17'hdbc, 17'h54c, 17'h55c, 17'h56c, 17'h57c,
    17'h64c, 17'h65c, 17'h52c, 17'h53c, 17'h24c, 17'h37c, 17'h38c, 17'h27c,
    17'h28c, 17'h58c, 17'h59c, 17'h2bc, 17'h2cc, 17'h5ac, 17'h66c, 17'h67c
  };

  // makeup codes for 64 .. 1728
  localparam logic [16:0] WHITE_MAKEUP [27] = '{
    17'h1b5, 17'h125, 17'h176, 17'h377, 17'h368, 17'h378, 17'h648, 17'h658,
    17'h688, 17'h678, 17'hcc9, 17'hcd9, 17'hd29, 17'hd39, 17'hd49, 17'hd59,
    17'hd69, 17'hd79, 17'hd89, 17'hd99, 17'hda9, 17'hdb9, 17'h989, 17'h999,
    17'h9a9, 17'h186, 17'h9b9
  };

  localparam logic [16:0] BLACK_MAKEUP [27] = '{
    17'h0fa, 17'hc8c, 17'hc9c, 17'h5bc, 17'h33c, 17'h34c, 17'h35c, 17'h6cd,
    17'h6dd, 17'h4ad, 17'h4bd, 17'h4cd, 17'h4dd, 17'h72d, 17'h73d, 17'h74d,
    17'h75d, 17'h76d, 17'h77d, 17'h52d, 17'h53d, 17'h54d, 17'h55d, 17'h5ad,
    17'h5bd, 17'h64d, 17'h65d
  };

  // extended makeup codes for 1792 .. 2560, shared by both colours
  localparam logic [16:0] EXT_MAKEUP [13] = '{
    17'h08b, 17'h0cb, 17'h0db, 17'h12c, 17'h13c, 17'h14c, 17'h15c,
    17'h16c, 17'h17c, 17'h1cc, 17'h1dc, 17'h1ec, 17'h1fc
  };

  // terminating code for a remainder of 0..63
  function automatic code_t term_code(input logic colour, input logic [5:0] t);
    code_t c;
    if (colour == COLOUR_BLACK) begin
      c = code_t'(BLACK_TERM[t]);
    end else begin
      c = code_t'(WHITE_TERM[t]);
    end
    return c;
  endfunction

  // makeup code for m multiples of 64, m >= 1
  function automatic code_t makeup_code(input logic colour, input logic [5:0] m);
    logic [5:0] mc;
    logic [5:0] idx;
    code_t      c;
    mc = (m > MAKEUP_LAST) ? MAKEUP_LAST : m;
    if (mc <= MAKEUP_STD_LAST) begin
      idx = mc - 6'd1;
      if (colour == COLOUR_BLACK) begin
        c = code_t'(BLACK_MAKEUP[idx[4:0]]);
      end else begin
        c = code_t'(WHITE_MAKEUP[idx[4:0]]);
      end
    end else begin
      idx = mc - MAKEUP_EXT_FIRST;
      c   = code_t'(EXT_MAKEUP[idx[3:0]]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/fax_g3_1d_run_length_encoder.sv -----
// One-dimensional modified Huffman (T.4) scanline encoder.
// Input stream: one pixel per transfer in in_tdata[0] (1 white, 0 black).
// Output stream: one code word per transfer, right aligned, sent MSB first,
// with its length and the running bit count of the line; out_tlast marks the
// last code of a scanline. No EOL code is inserted.
// Configuration: cfg_wr_en with cfg_wr_data sets the line width in pixels
// (0 acts as 1, values above MAX_LINE_WIDTH act as MAX_LINE_WIDTH).
// Path: the event register loads at the pixel transfer and feeds the output
// register, which drives out_tvalid; a receiver stall can hold a code between.
// Throughput: one pixel per cycle while each pixel ends at most one code and
// out_tready is high; a pixel that yields k codes (k up to 3) holds in_tready
// low until the event register, which hands out one code per cycle while
// the output is not stalled, has sent all but the last of them.
// Reset: line width returns to 1728, a new line starts with a white run,
// any codes not yet transferred are dropped.
// Receiver stall: the output register holds its code, the event register
// holds the pending codes and in_tready drops once the event is pending.
`default_nettype none

module fax_g3_1d_run_length_encoder #(
  parameter int MAX_LINE_WIDTH = 2560
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,   // line_width
  // pixel input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [0] pixel_bit, [7:1] zero
  // code output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,     // [12:0] code_bits, [16:13] code_length,
                                          // [32:17] line_bit_total, [39:33] zero
  output logic             out_tlast      // end_of_line
);

  logic              evt_push;
  logic              evt_ready;
  fax_g3_pkg::evt_t  evt;
  logic [12:0]       code_bits;
  logic [3:0]        code_length;
  logic [15:0]       line_bit_total;

  fax_g3_run_tracker #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_pixel    (in_tdata[0]),
    .in_ready    (in_tready),
    .evt_ready   (evt_ready),
    .evt_push    (evt_push),
    .evt         (evt)
  );

  fax_g3_code_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_push  (evt_push),
    .evt       (evt),
    .evt_ready (evt_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bits  (code_bits),
    .out_len   (code_length),
    .out_last  (out_tlast),
    .out_total (line_bit_total)
  );

  // pack output fields, first field in the low bits
  assign out_tdata = {7'd0, line_bit_total, code_length, code_bits};

endmodule

`default_nettype wire

// ----- src/fax_g3_run_tracker.sv -----
`default_nettype none

// Run tracking: per-pixel colour, run and position update plus event build.
module fax_g3_run_tracker #(
  parameter int MAX_LINE_WIDTH = 2560
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [11:0]      cfg_wr_data,
  input  wire logic             in_valid,
  input  wire logic             in_pixel,
  output logic                  in_ready,
  input  wire logic             evt_ready,
  output logic                  evt_push,
  output fax_g3_pkg::evt_t      evt
);

  `include "fax_g3_1d_run_length_encoder_assert.svh"

  localparam logic [11:0] MAX_W = 12'(MAX_LINE_WIDTH);

  logic        line_width_r;
  logic [11:0] width_r;
  logic        run_colour_r, run_colour_nxt;
  logic [11:0] run_length_r, run_length_nxt;
  logic [11:0] pos_r, pos_nxt;

  logic        accept;
  logic        colour;
  logic [11:0] w_eff;
  logic        rc_mid;
  logic [11:0] rl_mid;
  logic [11:0] rl_inc;
  logic [11:0] pos_inc;
  logic        eol;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= fax_g3_pkg::LINE_WIDTH_RESET;
      line_width_r <= 1'b0;
    end else if (cfg_wr_en) begin
      width_r      <= cfg_wr_data;
      line_width_r <= 1'b1;
    end
  end

  // effective width: zero acts as one, clamp at the maximum
  always_comb begin
    if (width_r == 12'd0) begin
      w_eff = 12'd1;
    end else if (width_r > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = width_r;
    end
  end

  assign accept   = in_valid & evt_ready;
  assign in_ready = evt_ready;
  assign colour   = ~in_pixel;

  // run bookkeeping for one pixel
  always_comb begin
    evt      = '0;
    rc_mid   = run_colour_r;
    rl_mid   = run_length_r;
    if (pos_r == 12'd0) begin
      rc_mid = fax_g3_pkg::COLOUR_WHITE;
      rl_mid = 12'd0;
      if (colour == fax_g3_pkg::COLOUR_BLACK) begin
        // line opens black: zero-length white run first
        evt.mask[fax_g3_pkg::SLOT_A_TM] = 1'b1;
        evt.a_colour = fax_g3_pkg::COLOUR_WHITE;
        evt.a_len    = 12'd0;
        rc_mid       = fax_g3_pkg::COLOUR_BLACK;
      end
    end else if (colour != run_colour_r) begin
      evt.mask[fax_g3_pkg::SLOT_A_MK] = |run_length_r[11:6];
      evt.mask[fax_g3_pkg::SLOT_A_TM] = 1'b1;
      evt.a_colour = run_colour_r;
      evt.a_len    = run_length_r;
      rc_mid       = colour;
      rl_mid       = 12'd0;
    end

    rl_inc  = rl_mid + 12'd1;
    pos_inc = pos_r + 12'd1;
    eol     = (pos_inc >= w_eff);

    evt.b_colour = rc_mid;
    evt.b_len    = rl_inc;
    if (eol) begin
      evt.mask[fax_g3_pkg::SLOT_B_MK] = |rl_inc[11:6];
      evt.mask[fax_g3_pkg::SLOT_B_TM] = 1'b1;
      run_colour_nxt = fax_g3_pkg::COLOUR_WHITE;
      run_length_nxt = 12'd0;
      pos_nxt        = 12'd0;
    end else begin
      run_colour_nxt = rc_mid;
      run_length_nxt = rl_inc;
      pos_nxt        = pos_inc;
    end
  end

  assign evt_push = accept && (evt.mask != 4'd0);

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_colour_r <= fax_g3_pkg::COLOUR_WHITE;
      run_length_r <= 12'd0;
      pos_r        <= 12'd0;
    end else if (accept) begin
      run_colour_r <= run_colour_nxt;
      run_length_r <= run_length_nxt;
      pos_r        <= pos_nxt;
    end
  end

  `FAX_G3_ASSERT(a_pos_in_line, pos_r < MAX_W || line_width_r)
  `FAX_G3_ASSERT(a_run_in_line, run_length_r <= pos_r)
  `FAX_G3_ASSERT_NEXT(a_black_tracked, accept && !in_pixel,
                      run_colour_r == fax_g3_pkg::COLOUR_BLACK || pos_r == 12'd0)

endmodule

`default_nettype wire

// ----- src/fax_g3_code_emit.sv -----
`default_nettype none

// Code emission: walks the code slots of one event, one code per cycle while
// the output is not stalled, keeps the line bit total and holds the output register.
module fax_g3_code_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             evt_push,
  input  wire fax_g3_pkg::evt_t evt,
  output logic                  evt_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [12:0]           out_bits,
  output logic [3:0]            out_len,
  output logic                  out_last,
  output logic [15:0]           out_total
);

  `include "fax_g3_1d_run_length_encoder_assert.svh"

  logic [3:0]  mask_r, mask_nxt;
  logic        a_colour_r, b_colour_r;
  logic [11:0] a_len_r, b_len_r;
  logic [15:0] bt_r, bt_nxt;
  logic        out_valid_r;
  logic [12:0] out_bits_r;
  logic [3:0]  out_len_r;
  logic        out_last_r;
  logic [15:0] out_total_r;

  logic              emit;
  logic [3:0]        sel;
  logic [3:0]        mask_left;
  logic              use_b;
  logic              is_mk;
  logic              s_colour;
  logic [11:0]       s_len;
  logic              last;
  fax_g3_pkg::code_t code;
  logic [15:0]       total;

  assign emit = (mask_r != 4'd0) && (!out_valid_r || out_ready);

  // lowest pending slot goes first
  always_comb begin
    sel = mask_r & (~mask_r + 4'd1);
  end

  // code lookup for the selected slot
  always_comb begin
    use_b    = sel[fax_g3_pkg::SLOT_B_MK] | sel[fax_g3_pkg::SLOT_B_TM];
    is_mk    = sel[fax_g3_pkg::SLOT_A_MK] | sel[fax_g3_pkg::SLOT_B_MK];
    s_colour = use_b ? b_colour_r : a_colour_r;
    s_len    = use_b ? b_len_r : a_len_r;
    last     = sel[fax_g3_pkg::SLOT_B_TM];
    if (is_mk) begin
      code = fax_g3_pkg::makeup_code(s_colour, s_len[11:6]);
    end else begin
      code = fax_g3_pkg::term_code(s_colour, s_len[5:0]);
    end
    total = bt_r + {12'd0, code.len};
  end

  // slots still pending after this cycle; a new event may load once the last
  // slot goes out
  assign mask_left = emit ? (mask_r & ~sel) : mask_r;
  assign evt_ready = (mask_left == 4'd0);

  // slot bookkeeping
  always_comb begin
    mask_nxt = mask_left;
    bt_nxt   = bt_r;
    if (emit) begin
      bt_nxt = last ? 16'd0 : total;
    end
    if (evt_push) begin
      mask_nxt = evt.mask;
    end
  end

  // event and bit-total registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'd0;
      bt_r   <= 16'd0;
    end else begin
      mask_r <= mask_nxt;
      bt_r   <= bt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_push) begin
      a_colour_r <= evt.a_colour;
      a_len_r    <= evt.a_len;
      b_colour_r <= evt.b_colour;
      b_len_r    <= evt.b_len;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bits_r  <= code.bits;
      out_len_r   <= code.len;
      out_last_r  <= last;
      out_total_r <= total;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bits  = out_bits_r;
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;
  assign out_total = out_total_r;

  `FAX_G3_ASSERT(a_push_when_ready, evt_push |-> evt_ready)
  `FAX_G3_ASSERT_NEXT(a_total_cleared, emit && last, bt_r == 16'd0)
  `FAX_G3_ASSERT(a_total_covers_code,
                 out_valid_r |-> out_total_r >= {12'd0, out_len_r})

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;

  localparam int          CYCLE_LIMIT = 200_000;
  localparam logic [11:0] LINE_MAX    = 12'd2560;
  localparam logic [11:0] WIDTH_RESET = 12'd1728;

  // code tables, each entry {code[12:0], len[3:0]}
  localparam logic [16:0] WHITE_TERM_TAB [64] = '{
    17'h358, 17'h076, 17'h074, 17'h084, 17'h0b4, 17'h0c4, 17'h0e4, 17'h0f4,
    17'h135, 17'h145, 17'h075, 17'h085, 17'h086, 17'h036, 17'h346, 17'h356,
    17'h2a6, 17'h2b6, 17'h277, 17'h0c7, 17'h087, 17'h177, 17'h037, 17'h047,
    17'h287, 17'h2b7, 17'h137, 17'h247, 17'h187, 17'h028, 17'h038, 17'h1a8,
    17'h1b8, 17'h128, 17'h138, 17'h148, 17'h158, 17'h168, 17'h178, 17'h288,
    17'h298, 17'h2a8, 17'h2b8, 17'h2c8, 17'h2d8, 17'h048, 17'h058, 17'h0a8,
    17'h0b8, 17'h528, 17'h538, 17'h548, 17'h558, 17'h248, 17'h258, 17'h588,
    17'h598, 17'h5a8, 17'h5b8, 17'h4a8, 17'h4b8, 17'h328, 17'h338, 17'h348
  };

  localparam logic [16:0] BLACK_TERM_TAB [64] = '{
    17'h37a, 17'h023, 17'h032, 17'h022, 17'h033, 17'h034, 17'h024, 17'h035,
    17'h056, 17'h046, 17'h047, 17'h057, 17'h077, 17'h048, 17'h078, 17'h189,
    17'h17a, 17'h18a, 17'h08a, 17'h67b, 17'h68b, 17'h6cb, 17'h37b, 17'h28b,
    17'h17b, 17'h18b, 17'hcac, 17'hcbc, 17'hccc, 17'hcdc, 17'h68c, 17'h69c,
    17'h6ac, 17'h6bc, 17'hd2c, 17'hd3c, 17'hd4c, 17'hd5c, 17'hd6c, 17'hd7c,
    17'h6cc, 17'h6dc, 17'hdac, 17'hdbc, 17'h54c, 17'h55c, 17'h56c, 17'h57c,
    17'h64c, 17'h65c, 17'h52c, 17'h53c, 17'h24c, 17'h37c, 17'h38c, 17'h27c,
    17'h28c, 17'h58c, 17'h59c, 17'h2bc, 17'h2cc, 17'h5ac, 17'h66c, 17'h67c
  };

  // makeup codes for 64 .. 1728
  localparam logic [16:0] WHITE_MK_TAB [27] = '{
    17'h1b5, 17'h125, 17'h176, 17'h377, 17'h368, 17'h378, 17'h648, 17'h658,
    17'h688, 17'h678, 17'hcc9, 17'hcd9, 17'hd29, 17'hd39, 17'hd49, 17'hd59,
    17'hd69, 17'hd79, 17'hd89, 17'hd99, 17'hda9, 17'hdb9, 17'h989, 17'h999,
    17'h9a9, 17'h186, 17'h9b9
  };

  localparam logic [16:0] BLACK_MK_TAB [27] = '{
    17'h0fa, 17'hc8c, 17'hc9c, 17'h5bc, 17'h33c, 17'h34c, 17'h35c, 17'h6cd,
    17'h6dd, 17'h4ad, 17'h4bd, 17'h4cd, 17'h4dd, 17'h72d, 17'h73d, 17'h74d,
    17'h75d, 17'h76d, 17'h77d, 17'h52d, 17'h53d, 17'h54d, 17'h55d, 17'h5ad,
    17'h5bd, 17'h64d, 17'h65d
  };

  // shared makeup codes for 1792 .. 2560
  localparam logic [16:0] EXT_MK_TAB [13] = '{
    17'h08b, 17'h0cb, 17'h0db, 17'h12c, 17'h13c, 17'h14c, 17'h15c,
    17'h16c, 17'h17c, 17'h1cc, 17'h1dc, 17'h1ec, 17'h1fc
  };

  typedef struct {
    logic [12:0] bits;
    logic [3:0]  len;
    logic        eol;
    logic [15:0] total;
  } code_word_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [11:0] cfg_wr_data = 12'd0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // encoder state as predicted
  logic [11:0] enc_width;
  logic        enc_colour;
  logic [11:0] enc_run;
  logic [11:0] enc_pos;
  logic [15:0] enc_total;

  code_word_t  pending_codes [$];
  code_word_t  head_code;

  bit          idle_on       = 1'b1;
  int          stall_left    = 0;
  longint      cycle_count   = 0;
  int          mismatches    = 0;
  int          codes_checked = 0;
  int          codes_queued  = 0;
  int          pixels_sent   = 0;
  int          lines_done    = 0;
  int          makeup_codes  = 0;
  int          ext_codes     = 0;
  int          triple_pixels = 0;
  int          width_writes  = 0;

  fax_g3_1d_run_length_encoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Code prediction
  // ---------------------------------------------------------------------

  function automatic void emit_code(input logic [16:0] entry, input logic eol);
    code_word_t w;
    enc_total = enc_total + 16'(entry[3:0]);
    w.bits    = entry[16:4];
    w.len     = entry[3:0];
    w.eol     = eol;
    w.total   = enc_total;
    pending_codes.push_back(w);
    codes_queued++;
  endfunction

  // makeup for the multiples of 64 (clamped at 2560), then the remainder
  function automatic void emit_run(input logic colour, input logic [11:0] len,
                                   input logic eol);
    logic [5:0] mult;
    logic [5:0] rem;
    mult = len[11:6];
    rem  = len[5:0];
    if (mult > 6'd40) mult = 6'd40;
    if (mult != 6'd0) begin
      makeup_codes++;
      if (mult <= 6'd27) begin
        emit_code(colour == fax_g3_pkg::COLOUR_BLACK ? BLACK_MK_TAB[mult - 1]
                                                     : WHITE_MK_TAB[mult - 1], 1'b0);
      end else begin
        ext_codes++;
        emit_code(EXT_MK_TAB[mult - 28], 1'b0);
      end
    end
    emit_code(colour == fax_g3_pkg::COLOUR_BLACK ? BLACK_TERM_TAB[rem]
                                                 : WHITE_TERM_TAB[rem], eol);
  endfunction

  function automatic void encode_pixel(input logic px);
    logic        colour;
    logic [11:0] w;
    int          first;
    first  = codes_queued;
    colour = px ? fax_g3_pkg::COLOUR_WHITE : fax_g3_pkg::COLOUR_BLACK;
    w      = enc_width;
    if (w == 12'd0) w = 12'd1;
    if (w > LINE_MAX) w = LINE_MAX;

    // a line opens with a white run, zero length if the first pixel is black
    if (enc_pos == 12'd0) begin
      enc_colour = fax_g3_pkg::COLOUR_WHITE;
      enc_run    = 12'd0;
      enc_total  = 16'd0;
      if (colour == fax_g3_pkg::COLOUR_BLACK) begin
        emit_run(fax_g3_pkg::COLOUR_WHITE, 12'd0, 1'b0);
        enc_colour = fax_g3_pkg::COLOUR_BLACK;
      end
    end else if (colour != enc_colour) begin
      emit_run(enc_colour, enc_run, 1'b0);
      enc_colour = colour;
      enc_run    = 12'd0;
    end

    enc_run = enc_run + 12'd1;
    enc_pos = enc_pos + 12'd1;

    // end of line closes the current run
    if (enc_pos >= w) begin
      emit_run(enc_colour, enc_run, 1'b1);
      enc_colour = fax_g3_pkg::COLOUR_WHITE;
      enc_run    = 12'd0;
      enc_pos    = 12'd0;
      enc_total  = 16'd0;
      lines_done++;
    end
    if (codes_queued - first == 3) triple_pixels++;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // one pixel transfer, with an optional gap ahead of it
  task automatic send_pixel(input logic px);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, px};
    do @(posedge clk); while (!in_tready);
    encode_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_run(input logic px, input int n);
    repeat (n) send_pixel(px);
  endtask

  // n pixels taken from pat, lowest bit first
  task automatic send_pattern(input logic [15:0] pat, input int n);
    for (int k = 0; k < n; k++) send_pixel(pat[k]);
  endtask

  // pixels in runs of 1..max_run until the current line ends
  task automatic send_line(input int max_run);
    logic px;
    int   n;
    bit   done;
    px   = 1'($urandom_range(0, 1));
    done = 1'b0;
    do begin
      n = $urandom_range(1, max_run);
      for (int k = 0; k < n && !done; k++) begin
        send_pixel(px);
        if (enc_pos == 12'd0) done = 1'b1;
      end
      px = ~px;
    end while (!done);
  endtask

  // stop sending until every predicted code has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_width(input logic [11:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    enc_width = value;
    width_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // width after reset: long runs stay inside the 1728 pixel line
  task automatic test_reset_width();
    send_run(1'b1, 66);
    send_run(1'b0, 64);
    settle();
    // line still open at 130 pixels; a width of 131 ends it on the next pixel
    set_width(12'd131);
    send_pixel(1'b0);
    settle();
  endtask

  // narrow lines: width one, width zero, black first pixel, new run on last pixel
  task automatic test_short_lines();
    set_width(12'd1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    settle();
    set_width(12'd0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    settle();
    set_width(12'd3);
    send_pattern(16'b011, 3);
    send_pattern(16'b010, 3);
    settle();
    set_width(12'd5);
    send_pattern(16'b10101, 5);
    settle();
    set_width(12'd4);
    send_pattern(16'b0000, 4);
    settle();
  endtask

  // width changes while a line is open
  task automatic test_mid_line_width();
    set_width(12'd10);
    send_pattern(16'b100011, 6);
    settle();
    // pixel count already past the new width: line ends on the next pixel
    set_width(12'd4);
    send_pixel(1'b1);
    settle();
    set_width(12'd12);
    send_pattern(16'b00111, 5);
    settle();
    set_width(12'd6);
    send_pixel(1'b0);
    settle();
    set_width(12'd12);
    send_pattern(16'b1101, 4);
    settle();
    set_width(12'd20);
    send_line(4);
    settle();
  endtask

  // oversize width, makeup codes and three codes from one pixel
  task automatic test_long_runs();
    // oversize width acts as the maximum, so the line stays open
    set_width(12'd4095);
    send_run(1'b1, 10);
    settle();
    set_width(12'd4);
    send_pixel(1'b1);
    settle();
    set_width(12'd66);
    send_run(1'b1, 65);
    send_pixel(1'b0);
    settle();
    set_width(12'd130);
    send_run(1'b0, 129);
    send_pixel(1'b1);
    settle();
  endtask

  // random widths and pixel streams, quiet handshakes at the end
  task automatic test_random();
    int   start;
    int   run_hint;
    logic px;
    start    = pixels_sent;
    run_hint = 3;
    px       = 1'b1;
    while (pixels_sent - start < 66) begin
      if (pixels_sent - start > 40) idle_on = 1'b0;
      if (enc_pos == 12'd0) begin
        run_hint = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) begin
          settle();
          case ($urandom_range(0, 9))
            0:       set_width(12'd0);
            1:       set_width(12'd1);
            2:       set_width(12'($urandom_range(64, 150)));
            default: set_width(12'($urandom_range(2, 32)));
          endcase
        end
      end else if ($urandom_range(0, 39) == 0) begin
        settle();
        set_width(12'($urandom_range(1, 32)));
      end
      if ($urandom_range(0, 7) == 0) begin
        px = 1'($urandom_range(0, 1));
      end else if ($urandom_range(0, run_hint) == 0) begin
        px = ~px;
      end
      send_pixel(px);
    end
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stalls and checking
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 14);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at code %0d: expected 0x%0h, got 0x%0h",
               what, codes_checked, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_codes.size() == 0) begin
        flag_mismatch("unexpected code transfer", 0, out_tdata[12:0]);
      end else begin
        head_code = pending_codes.pop_front();
        if (out_tdata[12:0] !== head_code.bits)
          flag_mismatch("code_bits", head_code.bits, out_tdata[12:0]);
        if (out_tdata[16:13] !== head_code.len)
          flag_mismatch("code_length", head_code.len, out_tdata[16:13]);
        if (out_tlast !== head_code.eol)
          flag_mismatch("end_of_line", head_code.eol, out_tlast);
        if (out_tdata[32:17] !== head_code.total)
          flag_mismatch("line_bit_total", head_code.total, out_tdata[32:17]);
      end
      codes_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes outstanding",
               cycle_count, pending_codes.size());
      $display("** fax_g3_1d_run_length_encoder: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    enc_width  = WIDTH_RESET;
    enc_colour = fax_g3_pkg::COLOUR_WHITE;
    enc_run    = 12'd0;
    enc_pos    = 12'd0;
    enc_total  = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_width();
    test_short_lines();
    test_mid_line_width();
    test_long_runs();
    test_random();

    settle();
    repeat (20) @(posedge clk);
    if (pending_codes.size() != 0)
      flag_mismatch("codes never produced", pending_codes.size(), 0);

    $display("%0d pixels over %0d scanlines, %0d width writes, %0d code words checked",
             pixels_sent, lines_done, width_writes, codes_checked);
    $display("%0d makeup codes (%0d extended), %0d pixels ending three codes",
             makeup_codes, ext_codes, triple_pixels);
    if (mismatches == 0) begin
      $display("** fax_g3_1d_run_length_encoder: PASSED **");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("** fax_g3_1d_run_length_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/fax_g3_pkg.sv
src/fax_g3_run_tracker.sv
src/fax_g3_code_emit.sv
src/fax_g3_1d_run_length_encoder.sv
tb/tb.sv
